### rtl/cmd_pkg.sv
package cmd_pkg;

  localparam int NUM_MODULES = 32;
  localparam int MOD_IDX_W   = 5;
  localparam int MOD_NUM_W   = 7;
  localparam int DIV_W       = 28;
  localparam int DEN_W       = 16;
  localparam int CUR_MAX     = 10000;
  localparam int CUR_SCALE   = 1000;
  localparam int PWR_MAX     = 65535;
  localparam int CAPP_W      = 19;
  localparam int CAPI_W      = 17;

  // divide by 1000 as a shift by 3 and a multiply by ceil(2^32 / 125)
  localparam int SCALE_PRE   = 3;
  localparam int RECIP_W     = 26;
  localparam int SCALE_RECIP = 34359739;
  localparam int SCALE_SHIFT = 32;

  typedef enum logic [1:0] {
    OP_WRITE_STATUS = 2'd0,
    OP_START_PLAN   = 2'd1,
    OP_DISPATCH     = 2'd2,
    OP_NONE         = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_DEFAULT_V   = 3'd0,
    CFG_MIN_DIV_V   = 3'd1,
    CFG_MODULE_PWR  = 3'd2,
    CFG_MIN_MODULES = 3'd3,
    CFG_MAX_MODULES = 3'd4,
    CFG_SLOT_GC     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_I = 2'd0,
    PH_W = 2'd1,
    PH_S = 2'd2,
    PH_P = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  unit_id;
    logic [2:0]  slot_id;
    logic [4:0]  status_flags;
    logic [13:0] req_voltage;
    logic [13:0] min_voltage;
    logic [13:0] max_voltage;
    logic [15:0] power_value;
    logic [15:0] power_limit;
    logic [13:0] current_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  outlet_id;
    logic [15:0] power_budget;
    logic [15:0] power_set;
    logic [3:0]  module_count;
    logic [3:0]  module_mask;
    logic [13:0] current_set;
    logic [13:0] voltage_set;
    logic        gun_contactor_closed;
    logic [7:0]  island_id;
  } out_item_t;

  typedef struct packed {
    logic   idle;
    logic   clamp;
    logic   prep;
    logic   go;
    logic   capture;
    logic   walk_step;
    logic   out_load;
    phase_t phase;
  } ctrl_cmd_t;

  typedef struct packed {
    logic disp_fire;
    logic div_done;
    logic walk_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

### rtl/cmd_stream_if.sv
interface cmd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/cmd_divider.sv
module cmd_divider
  import cmd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DEN_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/cmd_ctrl.sv
module cmd_ctrl
  import cmd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_PREP,
    S_GO,
    S_WAIT,
    S_WALK,
    S_SCALE,
    S_OUT
  } state_t;

  state_t state_r;
  phase_t phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_I;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (sts.disp_fire) state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          state_r <= S_PREP;
          phase_r <= PH_I;
        end
        S_PREP: state_r <= (phase_r == PH_P) ? S_SCALE : S_GO;
        S_GO:   state_r <= S_WAIT;
        S_WAIT: begin
          if (sts.div_done) begin
            unique case (phase_r)
              PH_I: begin
                state_r <= S_PREP;
                phase_r <= PH_W;
              end
              PH_W: state_r <= S_WALK;
              PH_S: begin
                state_r <= S_PREP;
                phase_r <= PH_P;
              end
              PH_P: state_r <= S_OUT;
            endcase
          end
        end
        S_WALK: begin
          if (sts.walk_last) begin
            state_r <= S_PREP;
            phase_r <= PH_S;
          end
        end
        S_SCALE: state_r <= S_OUT;
        S_OUT: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.phase     = phase_r;
    cmd.idle      = state_r == S_IDLE;
    cmd.clamp     = state_r == S_CLAMP;
    cmd.prep      = state_r == S_PREP;
    cmd.go        = state_r == S_GO;
    cmd.capture   = ((state_r == S_WAIT) && sts.div_done) || (state_r == S_SCALE);
    cmd.walk_step = state_r == S_WALK;
    cmd.out_load  = (state_r == S_OUT) && sts.out_free;
  end

endmodule

### rtl/cmd_datapath.sv
module cmd_datapath
  import cmd_pkg::*;
#(
  parameter int NUM_SLOTS        = 8,
  parameter int MODULES_PER_SLOT = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  cmd_stream_if.sink   in_ch,
  cmd_stream_if.source out_ch,
  input  ctrl_cmd_t    cmd,
  output ctrl_sts_t    sts
);

  localparam int KW = (MODULES_PER_SLOT > 1) ? $clog2(MODULES_PER_SLOT) : 1;
  localparam int SC_IN_W   = DIV_W - SCALE_PRE;
  localparam int SC_PROD_W = SC_IN_W + RECIP_W;
  localparam int SC_Q_W    = SC_PROD_W - SCALE_SHIFT;

  // configuration
  logic [13:0] dflt_v_r, min_div_v_r;
  logic [15:0] mod_pwr_r;
  logic [3:0]  min_mod_r, max_mod_r;
  logic [7:0]  slot_gc_r;

  // module table
  logic [3:0]  mod_status_r [NUM_MODULES];
  logic [15:0] mod_pwr_tab_r [NUM_MODULES];
  logic [13:0] mod_cur_tab_r [NUM_MODULES];
  logic [NUM_MODULES-1:0] mod_used_r;
  logic [7:0]  island_r;

  // dispatch working registers
  in_item_t         item_r;
  logic             route_r;
  logic [13:0]      v_r;
  logic [15:0]      p_r;
  logic [13:0]      i_r;
  logic [3:0]       want_r;
  logic [KW-1:0]    walk_k_r;
  logic [3:0]       got_r;
  logic [3:0]       mask_r;
  logic [CAPP_W-1:0] capp_r;
  logic [CAPI_W-1:0] capi_r;
  logic [13:0]      iset_r;
  logic [15:0]      pset_r;
  logic [DIV_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;

  out_item_t out_r;
  logic      out_valid_r;

  logic             in_fire;
  op_t              in_op;
  logic             div_done;
  logic [DIV_W-1:0] quo;

  // clamp
  logic [13:0] v0, v1, v2, v3;
  logic        route_c;
  logic [15:0] p0, p1;

  // capture helpers
  logic [13:0] q_cur_sat, i_lim, is0, is1, is2;
  logic [15:0] mp;
  logic [3:0]  minm, maxm, want_c;
  logic [DIV_W-1:0] want_lo;
  logic [15:0] pcap;

  // power setpoint scale by 1/1000
  logic [SC_PROD_W-1:0] scale_prod;
  logic [SC_Q_W-1:0]    scale_q;

  // walk
  logic [MOD_NUM_W-1:0] m_num;
  logic [MOD_IDX_W-1:0] m_idx;
  logic [3:0]  st;
  logic [15:0] m_pw;
  logic [13:0] m_cu;
  logic        m_take;

  logic routed;

  assign in_op   = op_t'(in_ch.data.operation);
  assign in_fire = in_ch.valid && cmd.idle;
  assign in_ch.ready = cmd.idle;

  assign sts.disp_fire = in_fire && (in_op == OP_DISPATCH) && in_ch.data.status_flags[0] &&
                         ({1'b0, in_ch.data.slot_id} < 4'(NUM_SLOTS));
  assign sts.div_done  = div_done;
  assign sts.walk_last = walk_k_r == KW'(MODULES_PER_SLOT - 1);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  cmd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.go),
    .dividend (num_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_v_r    <= 14'd4000;
      min_div_v_r <= 14'd500;
      mod_pwr_r   <= 16'd3000;
      min_mod_r   <= 4'd1;
      max_mod_r   <= 4'd4;
      slot_gc_r   <= 8'hff;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEFAULT_V:   dflt_v_r    <= cfg_wdata[13:0];
        CFG_MIN_DIV_V:   min_div_v_r <= cfg_wdata[13:0];
        CFG_MODULE_PWR:  mod_pwr_r   <= cfg_wdata;
        CFG_MIN_MODULES: min_mod_r   <= cfg_wdata[3:0];
        CFG_MAX_MODULES: max_mod_r   <= cfg_wdata[3:0];
        CFG_SLOT_GC:     slot_gc_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    v0 = (item_r.req_voltage != '0) ? item_r.req_voltage : dflt_v_r;
    v1 = (item_r.min_voltage != '0 && v0 < item_r.min_voltage) ? item_r.min_voltage : v0;
    v2 = (item_r.max_voltage != '0 && v1 > item_r.max_voltage) ? item_r.max_voltage : v1;
    v3 = (v2 < min_div_v_r) ? min_div_v_r : v2;
    route_c = item_r.status_flags[1] && !item_r.status_flags[2] &&
              !item_r.status_flags[3] && !item_r.status_flags[4];
    p0 = route_c ? item_r.power_value : '0;
    p1 = (item_r.power_limit != '0 && item_r.power_limit < p0) ? item_r.power_limit : p0;
  end

  always_comb begin
    q_cur_sat = (quo > DIV_W'(CUR_MAX)) ? 14'(CUR_MAX) : quo[13:0];
    i_lim = (p_r == '0 || v_r == '0) ? '0 : q_cur_sat;
    if (item_r.current_value != '0 && item_r.current_value < i_lim)
      i_lim = item_r.current_value;
    mp   = (mod_pwr_r != '0) ? mod_pwr_r : p_r;
    minm = (min_mod_r == '0) ? 4'd1 : min_mod_r;
    maxm = (max_mod_r == '0) ? 4'd1 : max_mod_r;
    want_lo = (quo < DIV_W'(minm)) ? DIV_W'(minm) : quo;
    want_c  = (want_lo > DIV_W'(maxm)) ? maxm : want_lo[3:0];
    pcap = (capp_r < CAPP_W'(p_r)) ? capp_r[15:0] : p_r;
    is0 = (v_r == '0) ? '0 : q_cur_sat;
    is1 = (item_r.current_value != '0 && item_r.current_value < is0) ?
          item_r.current_value : is0;
    is2 = (capi_r != '0 && capi_r < CAPI_W'(is1)) ? capi_r[13:0] : is1;
  end

  assign scale_prod = SC_PROD_W'(num_r[DIV_W-1:SCALE_PRE]) * SC_PROD_W'(SCALE_RECIP);
  assign scale_q    = scale_prod[SC_PROD_W-1:SCALE_SHIFT];

  always_comb begin
    m_num = MOD_NUM_W'(item_r.slot_id) * MOD_NUM_W'(MODULES_PER_SLOT) + MOD_NUM_W'(walk_k_r);
    m_idx = m_num[MOD_IDX_W-1:0];
    st    = mod_status_r[m_idx];
    m_pw  = mod_pwr_tab_r[m_idx];
    m_cu  = mod_cur_tab_r[m_idx];
    m_take = (m_num < MOD_NUM_W'(NUM_MODULES)) && st[0] && st[1] && !st[2] &&
             (!st[3] || m_pw != '0 || m_cu != '0) && !mod_used_r[m_idx] && (got_r < want_r);
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_WRITE_STATUS) begin
      mod_pwr_tab_r[in_ch.data.unit_id] <= in_ch.data.power_value;
      mod_cur_tab_r[in_ch.data.unit_id] <= in_ch.data.current_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_MODULES; k++) mod_status_r[k] <= '0;
      mod_used_r <= '0;
      island_r   <= 8'd1;
    end else begin
      if (in_fire && in_op == OP_WRITE_STATUS)
        mod_status_r[in_ch.data.unit_id] <= in_ch.data.status_flags[3:0];
      if (in_fire && in_op == OP_START_PLAN) begin
        mod_used_r <= '0;
        island_r   <= 8'd1;
      end
      if (cmd.walk_step && m_take) mod_used_r[m_idx] <= 1'b1;
      if (cmd.out_load) island_r <= (island_r == 8'hff) ? 8'd1 : island_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.disp_fire) item_r <= in_ch.data;
    if (cmd.clamp) begin
      v_r     <= v3;
      p_r     <= p1;
      route_r <= route_c;
    end
    if (cmd.prep) begin
      unique case (cmd.phase)
        PH_I: begin
          num_r <= DIV_W'(p_r) * DIV_W'(CUR_SCALE);
          den_r <= DEN_W'(v_r);
        end
        PH_W: begin
          num_r <= DIV_W'({1'b0, p_r} + {1'b0, mp} - 17'd1);
          den_r <= mp;
        end
        PH_S: begin
          num_r <= DIV_W'(pcap) * DIV_W'(CUR_SCALE);
          den_r <= DEN_W'(v_r);
        end
        PH_P: begin
          num_r <= DIV_W'(iset_r) * DIV_W'(v_r);
        end
      endcase
    end
    if (cmd.capture) begin
      unique case (cmd.phase)
        PH_I: i_r <= i_lim;
        PH_W: begin
          want_r   <= (i_r == '0) ? '0 : want_c;
          walk_k_r <= '0;
          got_r    <= '0;
          mask_r   <= '0;
          capp_r   <= '0;
          capi_r   <= '0;
        end
        PH_S: iset_r <= is2;
        PH_P: pset_r <= (scale_q > SC_Q_W'(PWR_MAX)) ? 16'(PWR_MAX) : scale_q[15:0];
      endcase
    end
    if (cmd.walk_step) begin
      walk_k_r <= walk_k_r + 1'b1;
      if (m_take) begin
        got_r  <= got_r + 4'd1;
        if (32'(walk_k_r) < 4) mask_r[2'(walk_k_r)] <= 1'b1;
        capp_r <= capp_r + CAPP_W'((m_pw != '0) ? m_pw : mod_pwr_r);
        capi_r <= capi_r + CAPI_W'(m_cu);
      end
    end
  end

  assign routed = route_r && (got_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.outlet_id            <= item_r.unit_id;
      out_r.power_budget         <= p_r;
      out_r.power_set            <= routed ? pset_r : '0;
      out_r.module_count         <= got_r;
      out_r.module_mask          <= mask_r;
      out_r.current_set          <= routed ? iset_r : '0;
      out_r.voltage_set          <= v_r;
      out_r.gun_contactor_closed <= slot_gc_r[item_r.slot_id] && routed;
      out_r.island_id            <= island_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

### rtl/charger_module_dispatch_core.sv
// charger module dispatch core
// in_ch carries one item per transfer: operation 0 writes a module's status
// entry, operation 1 starts a new plan, operation 2 dispatches one outlet.
// out_ch carries one result per dispatch of an active outlet on a valid slot;
// other items give no result.
// a dispatch runs three 28-bit divisions on one shared restoring divider,
// a walk over the slot's modules and a reciprocal scale of the power
// setpoint; the next item is taken once the result has been loaded into
// the output register. one item is worked on at a time. in_ch.ready is
// high whenever no dispatch is in progress. results sit in an output
// register; a stalled receiver holds the result and the block still takes
// new items, but a dispatch that finishes while the register is full waits
// there with in_ch.ready low until it is taken. cfg_we/cfg_index/cfg_wdata
// write configuration registers; the user must write them only while idle,
// as the block itself does not enforce this. reset restores the default
// configuration, marks all modules not present, clears used marks and sets
// the island counter to one.
module charger_module_dispatch_core
  import cmd_pkg::*;
#(
  parameter int NUM_SLOTS        = 8,
  parameter int MODULES_PER_SLOT = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  cmd_stream_if.sink   in_ch,
  cmd_stream_if.source out_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  cmd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  cmd_datapath #(
    .NUM_SLOTS        (NUM_SLOTS),
    .MODULES_PER_SLOT (MODULES_PER_SLOT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### rtl/cmd_checker.sv
module cmd_checker
  import cmd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_gc_needs_modules: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.gun_contactor_closed || (out_data.module_count != '0))
    else $error("gun contactor closed without modules");

  a_no_modules_no_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.module_count == '0) |->
      (out_data.power_set == '0) && (out_data.current_set == '0))
    else $error("setpoint without modules");

  a_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(out_data.module_mask) <= 32'(out_data.module_count))
    else $error("module mask exceeds assigned count");

endmodule

bind charger_module_dispatch_core cmd_checker u_cmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

### bench/charger_module_dispatch_core_test.sv
`timescale 1ns / 1ps

module charger_module_dispatch_core_test;
  import cmd_pkg::*;

  localparam int SLOTS = 8;
  localparam int PER_SLOT = 4;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  cmd_stream_if #(.T(in_item_t)) in_ch ();
  cmd_stream_if #(.T(out_item_t)) out_ch ();

  charger_module_dispatch_core #(
    .NUM_SLOTS(SLOTS),
    .MODULES_PER_SLOT(PER_SLOT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // dispatcher state as the bench sees it
  logic [13:0] dflt_volt, min_div_volt;
  logic [15:0] mod_power;
  logic [3:0] min_mods, max_mods;
  logic [7:0] slot_gc;
  logic [3:0] mod_status [32];
  logic [15:0] mod_avail_pwr [32];
  logic [13:0] mod_avail_cur [32];
  logic mod_used [32];
  int unsigned island;

  in_item_t pending_items [$];
  out_item_t expected_dispatch [$];
  int errors = 0;
  int dispatch_count = 0;
  int status_writes = 0;
  int plan_starts = 0;
  int wrap_seen = 0;
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int idle_cycles = 0;

  function automatic int unsigned amps_of(int unsigned p, int unsigned v);
    longint unsigned q;
    if (v == 0) return 0;
    q = (longint'(p) * 1000) / v;
    return (q > 10000) ? 10000 : int'(q);
  endfunction

  function automatic int unsigned umin(int unsigned a, int unsigned b);
    return a < b ? a : b;
  endfunction

  function automatic int unsigned umax(int unsigned a, int unsigned b);
    return a > b ? a : b;
  endfunction

  task automatic dispatch_predict(input in_item_t it);
    int unsigned v, p, i, want, got, mask, capp, capi, pset, iset, mp, m;
    bit route, rdy, gc;
    out_item_t r;
    want = 0; got = 0; mask = 0; capp = 0; capi = 0; pset = 0; iset = 0;
    case (op_t'(it.operation))
      OP_WRITE_STATUS: begin
        mod_status[it.unit_id] = it.status_flags[3:0];
        mod_avail_pwr[it.unit_id] = it.power_value;
        mod_avail_cur[it.unit_id] = it.current_value;
        status_writes++;
      end
      OP_START_PLAN: begin
        for (int k = 0; k < 32; k++) mod_used[k] = 1'b0;
        island = 1;
        plan_starts++;
      end
      OP_DISPATCH: begin
        if (it.status_flags[0] && it.slot_id < SLOTS) begin
          route = it.status_flags[1] && !it.status_flags[2] && !it.status_flags[3]
                  && !it.status_flags[4];
          v = it.req_voltage > 0 ? it.req_voltage : dflt_volt;
          if (it.min_voltage > 0) v = umax(v, it.min_voltage);
          if (it.max_voltage > 0) v = umin(v, it.max_voltage);
          v = umax(v, min_div_volt);
          p = route ? it.power_value : 0;
          if (it.power_limit > 0) p = umin(p, it.power_limit);
          i = p > 0 ? amps_of(p, v) : 0;
          if (it.current_value > 0) i = umin(i, it.current_value);
          if (i > 0 && v > 0) begin
            mp = mod_power > 0 ? mod_power : p;
            if (mp > 0) want = (p + mp - 1) / mp;
            want = umax(want, umax(1, min_mods));
            want = umin(want, umax(1, max_mods));
          end
          for (int k = 0; k < PER_SLOT && got < want; k++) begin
            m = it.slot_id * PER_SLOT + k;
            if (m < 32 && mod_status[m][0]) begin
              rdy = !mod_status[m][3] || mod_avail_pwr[m] > 0 || mod_avail_cur[m] > 0;
              if (mod_status[m][1] && !mod_status[m][2] && rdy && !mod_used[m]) begin
                mod_used[m] = 1'b1;
                got++;
                mask |= 1 << k;
                capp += mod_avail_pwr[m] > 0 ? mod_avail_pwr[m] : mod_power;
                capi += mod_avail_cur[m];
              end
            end
          end
          gc = slot_gc[it.slot_id] && route && got > 0;
          if (route && got > 0) begin
            pset = umin(p, capp);
            iset = amps_of(pset, v);
            if (it.current_value > 0) iset = umin(iset, it.current_value);
            if (capi > 0) iset = umin(iset, capi);
            pset = (iset * v) / 1000;
            if (pset > 65535) pset = 65535;
          end
          r.outlet_id = it.unit_id;
          r.power_budget = p[15:0];
          r.power_set = pset[15:0];
          r.module_count = got[3:0];
          r.module_mask = mask[3:0];
          r.current_set = iset[13:0];
          r.voltage_set = v[13:0];
          r.gun_contactor_closed = gc;
          r.island_id = island[7:0];
          expected_dispatch = {expected_dispatch, r};
          if (island >= 255) begin
            island = 1;
            wrap_seen++;
          end else begin
            island = island + 1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input int got_v, input int exp_v);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got_v, exp_v, $realtime);
  endtask

  // input driver
  int in_gap = 0;
  always @(posedge clk) begin
    logic next_valid;
    in_item_t next_data;
    next_valid = in_ch.valid;
    next_data = in_ch.data;
    if (!rst_n) begin
      next_valid = 1'b0;
      next_data = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        dispatch_predict(in_ch.data);
        next_valid = 1'b0;
        if (!quiet && $urandom_range(0, 99) < 20) in_gap = $urandom_range(1, 17);
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          next_data = pending_items.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    in_ch.valid <= next_valid;
    in_ch.data <= next_data;
  end

  // result monitor
  int out_hold = 0;
  always @(posedge clk) begin
    out_item_t want_r, got_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_r = out_ch.data;
        if (expected_dispatch.size() == 0) begin
          errors++;
          $display("unexpected result for outlet %0d at %0t", got_r.outlet_id, $realtime);
        end else begin
          want_r = expected_dispatch.pop_front();
          dispatch_count++;
          if (got_r.outlet_id !== want_r.outlet_id)
            report("outlet_id", got_r.outlet_id, want_r.outlet_id);
          if (got_r.power_budget !== want_r.power_budget)
            report("power_budget", got_r.power_budget, want_r.power_budget);
          if (got_r.power_set !== want_r.power_set)
            report("power_set", got_r.power_set, want_r.power_set);
          if (got_r.module_count !== want_r.module_count)
            report("module_count", got_r.module_count, want_r.module_count);
          if (got_r.module_mask !== want_r.module_mask)
            report("module_mask", got_r.module_mask, want_r.module_mask);
          if (got_r.current_set !== want_r.current_set)
            report("current_set", got_r.current_set, want_r.current_set);
          if (got_r.voltage_set !== want_r.voltage_set)
            report("voltage_set", got_r.voltage_set, want_r.voltage_set);
          if (got_r.gun_contactor_closed !== want_r.gun_contactor_closed)
            report("gun_contactor_closed", got_r.gun_contactor_closed,
                   want_r.gun_contactor_closed);
          if (got_r.island_id !== want_r.island_id)
            report("island_id", got_r.island_id, want_r.island_id);
        end
      end
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        out_hold = 400;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 8) begin
        out_hold = $urandom_range(1, 17);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(int op_weight_plan);
    in_item_t it;
    int sel;
    it = '0;
    sel = $urandom_range(0, 99);
    it.unit_id = $urandom_range(0, 31);
    it.slot_id = $urandom_range(0, 7);
    it.req_voltage = ($urandom_range(0, 9) == 0) ? 14'd0 : 14'($urandom_range(0, 15000));
    it.min_voltage = ($urandom_range(0, 2) == 0) ? 14'd0 : 14'($urandom_range(0, 15000));
    it.max_voltage = ($urandom_range(0, 2) == 0) ? 14'd0 : 14'($urandom_range(0, 15000));
    it.power_value = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
    it.power_limit = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
    it.current_value = ($urandom_range(0, 3) == 0) ? 14'd0 : 14'($urandom_range(0, 10000));
    if (sel < 25) begin
      it.operation = OP_WRITE_STATUS;
      it.status_flags = ($urandom_range(0, 99) < 60) ? 5'b00011 : 5'($urandom);
      if ($urandom_range(0, 1)) it.power_value = '0;
      if ($urandom_range(0, 1)) it.current_value = '0;
    end else if (sel < 25 + op_weight_plan) begin
      it.operation = OP_START_PLAN;
    end else if (sel < 95) begin
      it.operation = OP_DISPATCH;
      it.status_flags = ($urandom_range(0, 99) < 70) ? 5'b00011 : 5'($urandom);
    end else begin
      it.operation = OP_NONE;
      it.status_flags = 5'($urandom);
    end
    return it;
  endfunction

  task automatic drain_and_settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_dispatch.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(int dv, int mdv, int mp, int mnm, int mxm, int gc);
    int vals [6];
    vals = '{dv, mdv, mp, mnm, mxm, gc};
    for (int k = 0; k < 6; k++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(k);
      cfg_wdata <= 16'(vals[k]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    dflt_volt = 14'(dv); min_div_volt = 14'(mdv); mod_power = 16'(mp);
    min_mods = 4'(mnm); max_mods = 4'(mxm); slot_gc = 8'(gc);
  endtask

  task automatic add(int op, int unit, int slot, int fl, int rv, int nv, int xv,
                     int pv, int pl, int cv);
    in_item_t it;
    it.operation = 2'(op); it.unit_id = 5'(unit); it.slot_id = 3'(slot);
    it.status_flags = 5'(fl);
    it.req_voltage = 14'(rv); it.min_voltage = 14'(nv); it.max_voltage = 14'(xv);
    it.power_value = 16'(pv); it.power_limit = 16'(pl); it.current_value = 14'(cv);
    pending_items = {pending_items, it};
  endtask

  initial begin
    dflt_volt = 4000; min_div_volt = 500; mod_power = 3000;
    min_mods = 1; max_mods = 4; slot_gc = 8'hFF;
    for (int k = 0; k < 32; k++) begin
      mod_status[k] = '0; mod_avail_pwr[k] = '0; mod_avail_cur[k] = '0; mod_used[k] = 1'b0;
    end
    island = 1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: module table corners and dispatch corners at reset config
    add(OP_WRITE_STATUS, 0, 0, 5'b00011, 0, 0, 0, 0, 0, 0);
    add(OP_WRITE_STATUS, 1, 0, 5'b01011, 0, 0, 0, 0, 0, 0);
    add(OP_WRITE_STATUS, 2, 0, 5'b00111, 0, 0, 0, 500, 0, 100);
    add(OP_WRITE_STATUS, 3, 0, 5'b11011, 0, 0, 0, 65535, 0, 10000);
    add(OP_WRITE_STATUS, 28, 7, 5'b00011, 0, 0, 0, 1, 0, 1);
    add(OP_WRITE_STATUS, 31, 7, 5'b01011, 0, 0, 0, 0, 0, 1);
    add(OP_DISPATCH, 31, 0, 5'b00011, 15000, 15000, 15000, 65535, 65535, 10000);
    add(OP_DISPATCH, 0, 7, 5'b00011, 0, 0, 0, 65535, 0, 0);
    add(OP_DISPATCH, 5, 0, 5'b00010, 1000, 0, 0, 1000, 0, 0);
    add(OP_DISPATCH, 6, 7, 5'b10011, 1000, 0, 0, 1000, 0, 0);
    add(OP_DISPATCH, 7, 7, 5'b01111, 1, 0, 0, 65535, 0, 0);
    add(OP_NONE, 31, 7, 5'b11111, 15000, 15000, 15000, 65535, 65535, 10000);
    add(OP_START_PLAN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add(OP_DISPATCH, 1, 0, 5'b00011, 500, 600, 400, 0, 0, 0);
    add(OP_DISPATCH, 2, 0, 5'b00011, 0, 0, 0, 65535, 1, 1);
    add(OP_WRITE_STATUS, 3, 0, 5'b00000, 0, 0, 0, 0, 0, 0);
    add(OP_DISPATCH, 3, 0, 5'b00011, 0, 0, 0, 40000, 0, 0);
    drain_and_settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(0, 0, 0, 0, 0, 0);
        1: set_config(15000, 15000, 65535, 8, 8, 8'hAA);
        2: set_config(1200, 1, 1, 1, 1, 8'h55);
        3: set_config($urandom_range(0, 15000), $urandom_range(1, 15000),
                      $urandom_range(0, 65535), $urandom_range(1, 8),
                      $urandom_range(1, 8), $urandom_range(0, 255));
        4: set_config(4000, 500, 3000, 1, 4, 255);
        default: set_config(3000, 200, 500, 2, 8, 8'hF0);
      endcase
      if (ph == 0)
        add(OP_DISPATCH, 9, 2, 5'b00011, 0, 0, 0, 300, 0, 0);
      if (ph == 1) long_hold_req = 1'b1;
      if (ph == 5) quiet = 1'b1;
      // plan starts left out of the third phase so the island number wraps
      for (int n = 0; n < (ph == 2 ? 460 : 165); n++)
        pending_items = {pending_items, make_item(ph == 2 ? 0 : 4)};
      drain_and_settle();
    end

    $display("covered %0d status writes, %0d plan starts, %0d dispatch results",
             status_writes, plan_starts, dispatch_count);
    $display("six configuration settings, island wraps seen: %0d", wrap_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### charger_module_dispatch_core.f
rtl/cmd_pkg.sv
rtl/cmd_stream_if.sv
rtl/cmd_divider.sv
rtl/cmd_ctrl.sv
rtl/cmd_datapath.sv
rtl/charger_module_dispatch_core.sv
rtl/cmd_checker.sv
bench/charger_module_dispatch_core_test.sv
